/* hw/rtl/fcp_pkg.sv */
// fcp_pkg: shared types, constants and lookup functions for the clarke/park transform block
// no dependencies; imported by fcp_front, fcp_queue, fcp_back and the top module of the block

package fcp_pkg;

   // queued sample set between front and back
   typedef struct packed {
      logic [15:0]        angle;
      logic signed [12:0] avg_u;
      logic signed [12:0] avg_v;
      logic signed [12:0] avg_w;
      logic signed [15:0] volt_d;
      logic signed [15:0] volt_q;
   } fcp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fcp_q_status_type;

   localparam logic [11:0] ENC_MAX   = 12'd2879;
   localparam logic [18:0] ENC_SCALE = 19'd372827;

   localparam logic signed [18:0] CUR_SCALE = 19'sd175698;
   localparam logic signed [12:0] ALPHA_U   = 13'sd2731;
   localparam logic signed [12:0] ALPHA_VW  = 13'sd1365;
   localparam logic signed [12:0] BETA_K    = 13'sd2365;

   // first quarter wave of the sine table, S0.15
   localparam logic [15:0] QTR_ROM [0:16] = '{
      16'd0,     16'd3212,  16'd6393,  16'd9512,  16'd12539, 16'd15446,
      16'd18204, 16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898,
      16'd30273, 16'd31356, 16'd32137, 16'd32609, 16'd32767
   };

   // 64-step sine, entry 64 equals entry 0 so the index wraps
   function automatic logic signed [15:0] fcp_sin(input logic [5:0] idx);
      logic [4:0]  k;
      logic [15:0] mag;
      k = {1'b0, idx[3:0]};
      if (idx[4]) begin
         k = 5'd16 - k;
      end
      mag = QTR_ROM[k];
      return idx[5] ? signed'(16'(-mag)) : signed'(mag);
   endfunction

   function automatic logic [15:0] fcp_hall_angle(input logic [2:0] sector);
      logic [15:0] ang;
      unique case (sector)
         3'd1:    ang = 16'd54613;
         3'd2:    ang = 16'd10923;
         3'd4:    ang = 16'd32768;
         3'd5:    ang = 16'd43691;
         3'd6:    ang = 16'd21845;
         default: ang = 16'd0;
      endcase
      return ang;
   endfunction

endpackage

/* hw/rtl/fcp_front.sv */
// fcp_front: input register stage; selects the electrical angle and averages the adc pairs
// depends on fcp_pkg; feeds fcp_queue

module fcp_front
   import fcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_adc_zero_ref,
   input  logic [11:0]        req_adc_u_first,
   input  logic [11:0]        req_adc_v_first,
   input  logic [11:0]        req_adc_w_first,
   input  logic [11:0]        req_adc_w_second,
   input  logic [11:0]        req_adc_v_second,
   input  logic [11:0]        req_adc_u_second,
   input  logic [11:0]        req_encoder_position,
   input  logic [2:0]         req_hall_sector,
   input  logic signed [15:0] req_angle_correction,
   input  logic signed [15:0] req_volt_d_cmd,
   input  logic signed [15:0] req_volt_q_cmd,
   input  logic               hall_mode,
   input  fcp_q_status_type   q_status,
   output logic               push,
   output fcp_item_type       push_item
);

   logic         valid_ff;
   fcp_item_type item_ff;
   fcp_item_type item_in;
   logic         load;
   logic [11:0]  enc_clamp;
   logic [30:0]  enc_prod;
   logic [15:0]  base_angle;
   logic [12:0]  sum_u, sum_v, sum_w;

   assign push      = valid_ff && !q_status.full;
   assign load      = !valid_ff || push;
   assign req_stall = !load;
   assign push_item = item_ff;

   assign enc_clamp = (req_encoder_position > ENC_MAX) ? ENC_MAX : req_encoder_position;
   assign enc_prod  = 31'(enc_clamp) * 31'(ENC_SCALE);
   assign base_angle = hall_mode ? fcp_hall_angle(req_hall_sector) : enc_prod[29:14];

   assign sum_u = {1'b0, req_adc_u_first} + {1'b0, req_adc_u_second};
   assign sum_v = {1'b0, req_adc_v_first} + {1'b0, req_adc_v_second};
   assign sum_w = {1'b0, req_adc_w_first} + {1'b0, req_adc_w_second};

   always_comb begin
      item_in.angle  = base_angle + req_angle_correction;
      item_in.avg_u  = signed'({1'b0, sum_u[12:1]} - {1'b0, req_adc_zero_ref});
      item_in.avg_v  = signed'({1'b0, sum_v[12:1]} - {1'b0, req_adc_zero_ref});
      item_in.avg_w  = signed'({1'b0, sum_w[12:1]} - {1'b0, req_adc_zero_ref});
      item_in.volt_d = req_volt_d_cmd;
      item_in.volt_q = req_volt_q_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
      end
      if (load && req_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

/* hw/rtl/fcp_queue.sv */
// fcp_queue: small fifo that decouples the front stage from the back pipeline
// depends on fcp_pkg

module fcp_queue
   import fcp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fcp_item_type     push_item,
   input  logic             pop,
   output fcp_item_type     pop_item,
   output fcp_q_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   fcp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/fcp_back.sv */
// fcp_back: four-stage pipeline for phase scaling, clarke, sin/cos interpolation, park and inverse park
// depends on fcp_pkg; pulls items from fcp_queue and holds the result register

module fcp_back
   import fcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  fcp_q_status_type   q_status,
   input  fcp_item_type       pop_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_elec_angle,
   output logic signed [15:0] rsp_current_alpha,
   output logic signed [15:0] rsp_current_beta,
   output logic signed [16:0] rsp_current_d,
   output logic signed [16:0] rsp_current_q,
   output logic signed [16:0] rsp_volt_alpha,
   output logic signed [16:0] rsp_volt_beta
);

   logic en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   // stage 1: phase currents and table reads
   logic signed [31:0] prod_u, prod_v, prod_w;
   logic [5:0]         idx0, idx1;
   logic signed [18:0] s1_pu_ff, s1_pv_ff, s1_pw_ff;
   logic signed [15:0] s1_sin0_ff, s1_sin1_ff, s1_cos0_ff, s1_cos1_ff;
   logic [6:0]         s1_frac_ff;
   logic [15:0]        s1_angle_ff;
   logic signed [15:0] s1_vd_ff, s1_vq_ff;

   // stage 2: clarke and interpolation
   logic signed [31:0] alpha_sum, beta_sum;
   logic signed [19:0] beta_diff;
   logic signed [8:0]  w0, w1;
   logic signed [24:0] sin_sum, cos_sum;
   logic signed [15:0] s2_alpha_ff, s2_beta_ff, s2_sin_ff, s2_cos_ff;
   logic [15:0]        s2_angle_ff;
   logic signed [15:0] s2_vd_ff, s2_vq_ff;

   // stage 3: park and inverse park products
   logic signed [31:0] s3_ca_ff, s3_sb_ff, s3_cb_ff, s3_sa_ff;
   logic signed [31:0] s3_cvd_ff, s3_svq_ff, s3_svd_ff, s3_cvq_ff;
   logic signed [15:0] s3_alpha_ff, s3_beta_ff;
   logic [15:0]        s3_angle_ff;

   // stage 4: sums, result register
   logic signed [32:0] d_sum, q_sum, va_sum, vb_sum;
   logic signed [16:0] s4_d_ff, s4_q_ff, s4_va_ff, s4_vb_ff;
   logic signed [15:0] s4_alpha_ff, s4_beta_ff;
   logic [15:0]        s4_angle_ff;

   // whole pipeline holds only while a finished result waits
   assign en  = !(s4_valid_ff && rsp_stall);
   assign pop = en && !q_status.empty;

   assign prod_u = pop_item.avg_u * CUR_SCALE;
   assign prod_v = pop_item.avg_v * CUR_SCALE;
   assign prod_w = pop_item.avg_w * CUR_SCALE;
   assign idx0   = pop_item.angle[15:10];
   assign idx1   = idx0 + 6'd1;

   assign alpha_sum = s1_pu_ff * ALPHA_U - s1_pv_ff * ALPHA_VW - s1_pw_ff * ALPHA_VW;
   assign beta_diff = s1_pv_ff - s1_pw_ff;
   assign beta_sum  = beta_diff * BETA_K;
   assign w1        = signed'({2'b00, s1_frac_ff});
   assign w0        = signed'(9'd128 - {2'b00, s1_frac_ff});
   assign sin_sum   = s1_sin0_ff * w0 + s1_sin1_ff * w1;
   assign cos_sum   = s1_cos0_ff * w0 + s1_cos1_ff * w1;

   assign d_sum  = s3_ca_ff + s3_sb_ff;
   assign q_sum  = s3_cb_ff - s3_sa_ff;
   assign va_sum = s3_cvd_ff - s3_svq_ff;
   assign vb_sum = s3_svd_ff + s3_cvq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= !q_status.empty;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         s1_pu_ff    <= prod_u[30:12];
         s1_pv_ff    <= prod_v[30:12];
         s1_pw_ff    <= prod_w[30:12];
         s1_sin0_ff  <= fcp_sin(idx0);
         s1_sin1_ff  <= fcp_sin(idx1);
         s1_cos0_ff  <= fcp_sin(idx0 + 6'd16);
         s1_cos1_ff  <= fcp_sin(idx1 + 6'd16);
         s1_frac_ff  <= pop_item.angle[9:3];
         s1_angle_ff <= pop_item.angle;
         s1_vd_ff    <= pop_item.volt_d;
         s1_vq_ff    <= pop_item.volt_q;

         s2_alpha_ff <= alpha_sum[30:15];
         s2_beta_ff  <= beta_sum[30:15];
         s2_sin_ff   <= sin_sum[22:7];
         s2_cos_ff   <= cos_sum[22:7];
         s2_angle_ff <= s1_angle_ff;
         s2_vd_ff    <= s1_vd_ff;
         s2_vq_ff    <= s1_vq_ff;

         s3_ca_ff    <= s2_cos_ff * s2_alpha_ff;
         s3_sb_ff    <= s2_sin_ff * s2_beta_ff;
         s3_cb_ff    <= s2_cos_ff * s2_beta_ff;
         s3_sa_ff    <= s2_sin_ff * s2_alpha_ff;
         s3_cvd_ff   <= s2_cos_ff * s2_vd_ff;
         s3_svq_ff   <= s2_sin_ff * s2_vq_ff;
         s3_svd_ff   <= s2_sin_ff * s2_vd_ff;
         s3_cvq_ff   <= s2_cos_ff * s2_vq_ff;
         s3_alpha_ff <= s2_alpha_ff;
         s3_beta_ff  <= s2_beta_ff;
         s3_angle_ff <= s2_angle_ff;

         s4_d_ff     <= d_sum[31:15];
         s4_q_ff     <= q_sum[31:15];
         s4_va_ff    <= va_sum[31:15];
         s4_vb_ff    <= vb_sum[31:15];
         s4_alpha_ff <= s3_alpha_ff;
         s4_beta_ff  <= s3_beta_ff;
         s4_angle_ff <= s3_angle_ff;
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_elec_angle    = s4_angle_ff;
   assign rsp_current_alpha = s4_alpha_ff;
   assign rsp_current_beta  = s4_beta_ff;
   assign rsp_current_d     = s4_d_ff;
   assign rsp_current_q     = s4_q_ff;
   assign rsp_volt_alpha    = s4_va_ff;
   assign rsp_volt_beta     = s4_vb_ff;

endmodule

/* hw/rtl/foc_clarke_park_transform_top.sv */
// foc_clarke_park_transform_top: angle selection, clarke, park and inverse park per sample set
// depends on fcp_pkg, fcp_front, fcp_queue, fcp_back
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid / req_stall | adc samples, encoder, hall, correction, vd/vq
//   rsp     | out       | rsp_valid / rsp_stall | angle, alpha/beta, d/q, volt alpha/beta
//   csr     | in        | csr_valid / csr_ready | hall_only_mode
//
// one item per cycle sustained while rsp_stall is low; an accepted item passes through the front register,
// the queue and the four back pipeline stages before it appears on rsp, later with a backlog.
// synchronous active-high reset empties the front, queue and pipeline and clears the mode.
// rsp_stall freezes the back pipeline; the queue and the front register absorb
// QUEUE_DEPTH + 1 items before req_stall rises. csr_ready is always high.

module foc_clarke_park_transform_top
   import fcp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_adc_zero_ref,
   input  logic [11:0]        req_adc_u_first,
   input  logic [11:0]        req_adc_v_first,
   input  logic [11:0]        req_adc_w_first,
   input  logic [11:0]        req_adc_w_second,
   input  logic [11:0]        req_adc_v_second,
   input  logic [11:0]        req_adc_u_second,
   input  logic [11:0]        req_encoder_position,
   input  logic [2:0]         req_hall_sector,
   input  logic signed [15:0] req_angle_correction,
   input  logic signed [15:0] req_volt_d_cmd,
   input  logic signed [15:0] req_volt_q_cmd,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_elec_angle,
   output logic signed [15:0] rsp_current_alpha,
   output logic signed [15:0] rsp_current_beta,
   output logic signed [16:0] rsp_current_d,
   output logic signed [16:0] rsp_current_q,
   output logic signed [16:0] rsp_volt_alpha,
   output logic signed [16:0] rsp_volt_beta,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_hall_only_mode
);

   logic             hall_mode_ff;
   logic             push, pop;
   fcp_item_type     push_item, pop_item;
   fcp_q_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hall_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         hall_mode_ff <= csr_hall_only_mode;
      end
   end

   fcp_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_adc_zero_ref     (req_adc_zero_ref),
      .req_adc_u_first      (req_adc_u_first),
      .req_adc_v_first      (req_adc_v_first),
      .req_adc_w_first      (req_adc_w_first),
      .req_adc_w_second     (req_adc_w_second),
      .req_adc_v_second     (req_adc_v_second),
      .req_adc_u_second     (req_adc_u_second),
      .req_encoder_position (req_encoder_position),
      .req_hall_sector      (req_hall_sector),
      .req_angle_correction (req_angle_correction),
      .req_volt_d_cmd       (req_volt_d_cmd),
      .req_volt_q_cmd       (req_volt_q_cmd),
      .hall_mode            (hall_mode_ff),
      .q_status             (q_status),
      .push                 (push),
      .push_item            (push_item)
   );

   fcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   fcp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_item          (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_elec_angle    (rsp_elec_angle),
      .rsp_current_alpha (rsp_current_alpha),
      .rsp_current_beta  (rsp_current_beta),
      .rsp_current_d     (rsp_current_d),
      .rsp_current_q     (rsp_current_q),
      .rsp_volt_alpha    (rsp_volt_alpha),
      .rsp_volt_beta     (rsp_volt_beta)
   );

endmodule

/* hw/rtl/fcp_checker.sv */
// fcp_checker: port-level assertions for the clarke/park transform block
// depends on foc_clarke_park_transform_top; attached through the bind below

module fcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_elec_angle,
   input logic [16:0] rsp_current_d,
   input logic [16:0] rsp_volt_alpha
);

   // reset empties the pipeline and the front register
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_reset_no_stall: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("req_stall high right after reset");

   // the queue can only fill while a result waits on the output
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_elec_angle)
         && $stable(rsp_current_d) && $stable(rsp_volt_alpha))
      else $error("stalled result changed");

endmodule

bind foc_clarke_park_transform_top fcp_checker u_fcp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_elec_angle (rsp_elec_angle),
   .rsp_current_d  (rsp_current_d),
   .rsp_volt_alpha (rsp_volt_alpha)
);
